// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, off while rst_n is low
`define ASSERT_IMPL(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/utf8cr_pkg.sv =====
package utf8cr_pkg;

    localparam int INDEX_WIDTH_DEFAULT = 16;

    localparam int TARGET_WIDTH = 16;
    localparam int CP_WIDTH     = 21;

    // configuration register indexes
    localparam logic CFG_TARGET_INDEX = 1'b0;
    localparam logic CFG_REPLACEMENT  = 1'b1;

    // code point range limits per encoded length
    localparam logic [CP_WIDTH-1:0] CP_MAX_1 = 21'h00007F;
    localparam logic [CP_WIDTH-1:0] CP_MAX_2 = 21'h0007FF;
    localparam logic [CP_WIDTH-1:0] CP_MAX_3 = 21'h00FFFF;
    localparam logic [CP_WIDTH-1:0] CP_MAX_4 = 21'h10FFFF;

    typedef enum logic [1:0] {
        PH_SCAN = 2'd0,
        PH_DROP = 2'd1,
        PH_PASS = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OUT_REPLACED  = 2'd0,
        OUT_BAD_LEAD  = 2'd1,
        OUT_BAD_CP    = 2'd2,
        OUT_NOT_FOUND = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } enc_t;

    // group of result bytes caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            byte_valid;
        logic            string_last;
        outcome_t        outcome;
    } burst_t;

    // character length from the lead byte, 0 for a bad lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= 8'h01 && b <= 8'h7f)
            len = 3'd1;
        else if (b >= 8'hc2 && b <= 8'hdf)
            len = 3'd2;
        else if (b >= 8'he0 && b <= 8'hef)
            len = 3'd3;
        else if (b >= 8'hf0 && b <= 8'hf4)
            len = 3'd4;
        return len;
    endfunction

    // utf-8 encoding of a code point, length 0 when out of range
    function automatic enc_t encode_cp(input logic [CP_WIDTH-1:0] cp);
        enc_t e;
        e.bytes = '0;
        e.len   = 3'd0;
        if (cp <= CP_MAX_1) begin
            e.bytes[0] = {1'b0, cp[6:0]};
            e.len      = 3'd1;
        end
        else if (cp <= CP_MAX_2) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end
        else if (cp <= CP_MAX_3) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end
        else if (cp <= CP_MAX_4) begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

// ===== rtl/utf8cr_scan.sv =====
`include "assert_macros.svh"

module utf8cr_scan #(
    parameter int INDEX_WIDTH = utf8cr_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // byte stream in
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,
    input  logic                                   s_tlast,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [utf8cr_pkg::CP_WIDTH-1:0]        cfg_data,
    // result groups toward the output stage
    output logic                                   burst_valid,
    input  logic                                   burst_ready,
    output utf8cr_pkg::burst_t                     burst
);
    import utf8cr_pkg::*;

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_last_reg;

    logic [TARGET_WIDTH-1:0]  target_reg;
    logic [CP_WIDTH-1:0]      repl_reg;

    logic [INDEX_WIDTH-1:0]   counter_reg, counter_next;
    logic [1:0]               skip_reg, skip_next;
    logic [1:0]               old_left_reg, old_left_next;
    phase_t                   phase_reg, phase_next;
    outcome_t                 outcome_reg, outcome_next;

    logic [INDEX_WIDTH-1:0]   target_cmp;
    enc_t                     enc;
    logic [2:0]               lead_len;
    logic [3:0][7:0]          out_bytes;
    logic [2:0]               n_bytes;
    logic                     push;
    logic                     consume;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            repl_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TARGET_INDEX: target_reg <= cfg_data[TARGET_WIDTH-1:0];
                CFG_REPLACEMENT:  repl_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // input register, refilled as soon as its byte is processed
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // character scan and replacement decision
    always_comb
    begin
        target_cmp    = INDEX_WIDTH'(target_reg);
        enc           = encode_cp(repl_reg);
        lead_len      = lead_length(in_byte_reg);
        out_bytes     = '0;
        n_bytes       = 3'd0;
        counter_next  = counter_reg;
        skip_next     = skip_reg;
        old_left_next = old_left_reg;
        phase_next    = phase_reg;
        outcome_next  = outcome_reg;
        case (phase_reg)
            PH_SCAN:
            begin
                if (skip_reg != 2'd0)
                begin
                    out_bytes[0] = in_byte_reg;
                    n_bytes      = 3'd1;
                    skip_next    = skip_reg - 2'd1;
                end
                else if (lead_len == 3'd0)
                begin
                    out_bytes[0] = in_byte_reg;
                    n_bytes      = 3'd1;
                    outcome_next = OUT_BAD_LEAD;
                    phase_next   = PH_PASS;
                end
                else if (counter_reg == target_cmp)
                begin
                    if (enc.len == 3'd0)
                    begin
                        out_bytes[0] = in_byte_reg;
                        n_bytes      = 3'd1;
                        outcome_next = OUT_BAD_CP;
                        phase_next   = PH_PASS;
                    end
                    else
                    begin
                        out_bytes     = enc.bytes;
                        n_bytes       = enc.len;
                        outcome_next  = OUT_REPLACED;
                        old_left_next = 2'(lead_len - 3'd1);
                        phase_next    = (lead_len == 3'd1) ? PH_PASS : PH_DROP;
                    end
                end
                else
                begin
                    out_bytes[0] = in_byte_reg;
                    n_bytes      = 3'd1;
                    skip_next    = 2'(lead_len - 3'd1);
                    counter_next = counter_reg + INDEX_WIDTH'(1);
                end
            end
            PH_DROP:
            begin
                old_left_next = old_left_reg - 2'd1;
                if (old_left_reg == 2'd1)
                    phase_next = PH_PASS;
            end
            default:
            begin
                out_bytes[0] = in_byte_reg;
                n_bytes      = 3'd1;
            end
        endcase
    end

    // result group: bytes, or an empty end marker for a dropped final byte
    always_comb
    begin
        burst.string_last = in_last_reg;
        burst.outcome     = outcome_next;
        if (n_bytes == 3'd0)
        begin
            burst.bytes      = '0;
            burst.last_idx   = 2'd0;
            burst.byte_valid = 1'b0;
        end
        else
        begin
            burst.bytes      = out_bytes;
            burst.last_idx   = 2'(n_bytes - 3'd1);
            burst.byte_valid = 1'b1;
        end
    end

    assign push        = in_valid_reg && (n_bytes != 3'd0 || in_last_reg);
    assign burst_valid = push;
    assign consume     = in_valid_reg && (burst_ready || !push);

    // string state, back to reset after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg  <= '0;
            skip_reg     <= 2'd0;
            old_left_reg <= 2'd0;
            phase_reg    <= PH_SCAN;
            outcome_reg  <= OUT_NOT_FOUND;
        end
        else if (consume)
        begin
            if (in_last_reg)
            begin
                counter_reg  <= '0;
                skip_reg     <= 2'd0;
                old_left_reg <= 2'd0;
                phase_reg    <= PH_SCAN;
                outcome_reg  <= OUT_NOT_FOUND;
            end
            else
            begin
                counter_reg  <= counter_next;
                skip_reg     <= skip_next;
                old_left_reg <= old_left_next;
                phase_reg    <= phase_next;
                outcome_reg  <= outcome_next;
            end
        end
    end

    `ASSERT_IMPL(a_drop_has_bytes, phase_reg == PH_DROP, old_left_reg != 2'd0, "drop with nothing left")
    `ASSERT_IMPL(a_skip_only_scan, skip_reg != 2'd0, phase_reg == PH_SCAN, "skip count outside scan")
    `ASSERT_IMPL(a_outcome_set, phase_reg != PH_SCAN, outcome_reg != OUT_NOT_FOUND, "scan left without outcome")

endmodule

// ===== rtl/utf8cr_emit.sv =====
`include "assert_macros.svh"

module utf8cr_emit (
    input  logic               clk,
    input  logic               rst_n,
    // result groups from the scan stage
    input  logic               burst_valid,
    output logic               burst_ready,
    input  utf8cr_pkg::burst_t burst,
    // result stream out
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [3:0]         m_tuser
);
    import utf8cr_pkg::*;

    logic       busy_reg;
    burst_t     burst_reg;
    logic [1:0] idx_reg;
    logic       run_last;
    logic       done;

    assign run_last    = idx_reg == burst_reg.last_idx;
    assign done        = busy_reg && m_tready && run_last;
    assign burst_ready = !busy_reg || done;

    // group holding register and byte pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (burst_ready)
        begin
            busy_reg <= burst_valid;
            idx_reg  <= 2'd0;
        end
        else if (m_tready)
            idx_reg <= idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (burst_valid && burst_ready)
            burst_reg <= burst;
    end

    // one result request per byte of the group
    assign m_tvalid   = busy_reg;
    assign m_tdata    = burst_reg.byte_valid ? burst_reg.bytes[idx_reg] : 8'd0;
    assign m_tlast    = run_last && burst_reg.string_last;
    assign m_tuser[0] = burst_reg.byte_valid;
    assign m_tuser[1] = run_last;
    assign m_tuser[3:2] = m_tlast ? burst_reg.outcome : OUT_REPLACED;

    `ASSERT_NEXT(a_hold_on_stall, busy_reg && !m_tready, busy_reg && $stable(idx_reg), "stalled group moved")
    `ASSERT_IMPL(a_idx_in_group, busy_reg, idx_reg <= burst_reg.last_idx, "pointer past group end")
    `ASSERT_IMPL(a_marker_shape, busy_reg && !burst_reg.byte_valid, burst_reg.last_idx == 2'd0 && burst_reg.string_last, "bad end marker")

endmodule

// ===== rtl/utf8_char_replace.sv =====
// UTF-8 character replacer: bytes of a string come in on s_*, one per request, and leave on
// m_* unchanged except for the character at position target_index (counted from zero), which
// is sent as the 1 to 4 byte encoding of replacement_code_point while its old continuation
// bytes are dropped. Character length is taken from the lead byte alone (01-7F, C2-DF, E0-EF,
// F0-F4); continuation bytes are not checked. The final result of each string carries the
// outcome: 0 replaced, 1 bad lead byte, 2 invalid code point, 3 index out of range; a dropped
// final byte yields an empty end marker (byte_valid low). Throughput is one byte per cycle
// while m_tready stays high. The output stage sends an n-byte replacement one byte per cycle,
// so the next passed byte waits until it is sent; old continuation bytes are dropped
// meanwhile and give no result. Data passes two registers (input register, result
// register). Write configuration only while no string is in flight.
module utf8_char_replace #(
    parameter int INDEX_WIDTH = utf8cr_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    output logic                            m_tlast,
    output logic [3:0]                      m_tuser,   // [0] byte_valid, [1] run_last,
                                                       // [3:2] outcome
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [utf8cr_pkg::CP_WIDTH-1:0] cfg_data
);
    import utf8cr_pkg::*;

    logic   burst_valid;
    logic   burst_ready;
    burst_t burst;

    // character scan and replacement
    utf8cr_scan #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    // byte-by-byte output
    utf8cr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== tb/utf8cr_stream_checker.sv =====
module utf8cr_stream_checker #(
    parameter int INDEX_WIDTH = utf8cr_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tlast,
    input  logic [3:0]                      m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [utf8cr_pkg::CP_WIDTH-1:0] cfg_data,
    output int                              mismatches,
    output int                              pending,
    output int                              results
);
    import utf8cr_pkg::*;

    // one output byte as the block should send it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_last;
        outcome_t   outcome;
    } out_item_t;

    out_item_t expected_bytes[$];

    // shadow registers
    logic [TARGET_WIDTH-1:0] tgt_index;
    logic [CP_WIDTH-1:0]     repl_cp;

    // per-string scan state
    logic [INDEX_WIDTH-1:0]  char_count;
    logic [1:0]              skip_left;
    logic [1:0]              drop_left;
    phase_t                  phase;
    outcome_t                str_outcome;

    int errs;
    int results_seen;

    // works out the output bytes for one accepted input byte
    task automatic predict_replace(input logic [7:0] b, input logic last);
        logic [7:0] emit [4];
        logic [2:0] len;
        int         n;
        out_item_t  item;

        n = 0;
        case (phase)
            PH_SCAN:
            begin
                if (skip_left != 2'd0)
                begin
                    emit[0]   = b;
                    n         = 1;
                    skip_left = skip_left - 2'd1;
                end
                else
                begin
                    // character length from the lead byte
                    if (b >= 8'h01 && b <= 8'h7f)
                        len = 3'd1;
                    else if (b >= 8'hc2 && b <= 8'hdf)
                        len = 3'd2;
                    else if (b >= 8'he0 && b <= 8'hef)
                        len = 3'd3;
                    else if (b >= 8'hf0 && b <= 8'hf4)
                        len = 3'd4;
                    else
                        len = 3'd0;

                    if (len == 3'd0)
                    begin
                        str_outcome = OUT_BAD_LEAD;
                        phase       = PH_PASS;
                        emit[0]     = b;
                        n           = 1;
                    end
                    else if (char_count == INDEX_WIDTH'(tgt_index))
                    begin
                        // encode the replacement code point
                        if (repl_cp <= 21'h00007f)
                        begin
                            emit[0] = repl_cp[7:0];
                            n       = 1;
                        end
                        else if (repl_cp <= 21'h0007ff)
                        begin
                            emit[0] = {3'b110, repl_cp[10:6]};
                            emit[1] = {2'b10, repl_cp[5:0]};
                            n       = 2;
                        end
                        else if (repl_cp <= 21'h00ffff)
                        begin
                            emit[0] = {4'b1110, repl_cp[15:12]};
                            emit[1] = {2'b10, repl_cp[11:6]};
                            emit[2] = {2'b10, repl_cp[5:0]};
                            n       = 3;
                        end
                        else if (repl_cp <= 21'h10ffff)
                        begin
                            emit[0] = {5'b11110, repl_cp[20:18]};
                            emit[1] = {2'b10, repl_cp[17:12]};
                            emit[2] = {2'b10, repl_cp[11:6]};
                            emit[3] = {2'b10, repl_cp[5:0]};
                            n       = 4;
                        end

                        if (n == 0)
                        begin
                            // invalid code point, rest goes through untouched
                            str_outcome = OUT_BAD_CP;
                            phase       = PH_PASS;
                            emit[0]     = b;
                            n           = 1;
                        end
                        else
                        begin
                            str_outcome = OUT_REPLACED;
                            drop_left   = 2'(len - 3'd1);
                            phase       = (drop_left != 2'd0) ? PH_DROP : PH_PASS;
                        end
                    end
                    else
                    begin
                        emit[0]    = b;
                        n          = 1;
                        skip_left  = 2'(len - 3'd1);
                        char_count = char_count + INDEX_WIDTH'(1);
                    end
                end
            end
            PH_DROP:
            begin
                drop_left = drop_left - 2'd1;
                if (drop_left == 2'd0)
                    phase = PH_PASS;
            end
            default:
            begin
                emit[0] = b;
                n       = 1;
            end
        endcase

        // dropped final byte still closes the string with an empty marker
        if (last && n == 0)
        begin
            item.out_byte    = 8'h00;
            item.byte_valid  = 1'b0;
            item.run_last    = 1'b1;
            item.string_last = 1'b1;
            item.outcome     = str_outcome;
            expected_bytes.push_back(item);
        end

        for (int k = 0; k < n; k++)
        begin
            item.out_byte    = emit[k];
            item.byte_valid  = 1'b1;
            item.run_last    = (k == n - 1);
            item.string_last = last && (k == n - 1);
            item.outcome     = (last && k == n - 1) ? str_outcome : OUT_REPLACED;
            expected_bytes.push_back(item);
        end

        // the next byte starts a new string
        if (last)
        begin
            char_count  = '0;
            skip_left   = 2'd0;
            drop_left   = 2'd0;
            phase       = PH_SCAN;
            str_outcome = OUT_NOT_FOUND;
        end
    endtask

    // follow configuration, predict on input requests, compare on output requests
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;

        if (!rst_n)
        begin
            tgt_index    = '0;
            repl_cp      = '0;
            char_count   = '0;
            skip_left    = 2'd0;
            drop_left    = 2'd0;
            phase        = PH_SCAN;
            str_outcome  = OUT_NOT_FOUND;
            errs         = 0;
            results_seen = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TARGET_INDEX)
                    tgt_index = cfg_data[TARGET_WIDTH-1:0];
                else
                    repl_cp = cfg_data;
            end

            if (s_tvalid && s_tready)
                predict_replace(s_tdata, s_tlast);

            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result: out_byte %h tuser %h tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    errs++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
                        errs++;
                    end
                    if (m_tuser[0] !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b", want.byte_valid, m_tuser[0]);
                        errs++;
                    end
                    if (m_tuser[1] !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last, m_tuser[1]);
                        errs++;
                    end
                    if (m_tlast !== want.string_last)
                    begin
                        $error("string_last: expected %b, got %b", want.string_last, m_tlast);
                        errs++;
                    end
                    if (m_tuser[3:2] !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", want.outcome, m_tuser[3:2]);
                        errs++;
                    end
                end
            end
        end

        mismatches <= errs;
        pending    <= expected_bytes.size();
        results    <= results_seen;
    end

endmodule

// ===== tb/tb_utf8_char_replace.sv =====
module tb_utf8_char_replace;
    import utf8cr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int RAND_BYTES  = 13;   // per idling mix

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = 8'h00;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tlast;
    logic [3:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_TARGET_INDEX;
    logic [CP_WIDTH-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int results;

    int   send_idle   = 0;
    int   recv_stall  = 0;
    logic long_hold   = 1'b0;
    int   hold_count  = 0;
    int   cycle_count = 0;
    int   bytes_sent  = 0;
    int   strings_sent = 0;

    logic [7:0] text_q[$];

    utf8_char_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    utf8cr_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .results    (results)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: random stalls, or a long hold-off counted here
    always @(posedge clk)
    begin
        if (long_hold && hold_count < HOLD_CYCLES)
        begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall);
            if (!long_hold)
                hold_count <= 0;
        end
    end

    // wait until every predicted byte has come out
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // one byte request, with optional idle cycles in front
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (send_idle != 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // send text_q as one string
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        strings_sent++;
    endtask

    // write both registers once the block is idle
    task automatic configure(input logic [TARGET_WIDTH-1:0] target,
                             input logic [CP_WIDTH-1:0] cp);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TARGET_INDEX;
        cfg_data  <= {{(CP_WIDTH - TARGET_WIDTH){1'b0}}, target};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_REPLACEMENT;
        cfg_data  <= cp;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [TARGET_WIDTH-1:0] target;
        logic [CP_WIDTH-1:0]     cp;

        if ($urandom_range(9) == 0)
            target = TARGET_WIDTH'($urandom_range(16'hffff));
        else
            target = TARGET_WIDTH'($urandom_range(5));
        case ($urandom_range(4))
            0:       cp = CP_WIDTH'($urandom_range(21'h00007f));
            1:       cp = CP_WIDTH'($urandom_range(21'h000080, 21'h0007ff));
            2:       cp = CP_WIDTH'($urandom_range(21'h000800, 21'h00ffff));
            3:       cp = CP_WIDTH'($urandom_range(21'h010000, 21'h10ffff));
            default: cp = CP_WIDTH'($urandom_range(21'h110000, 21'h1fffff));
        endcase
        configure(target, cp);
    endtask

    // mostly well-formed characters, some bad leads, noise and cut-off ends
    task automatic make_text();
        int nchars;
        int len;
        int pick;

        text_q.delete();
        nchars = $urandom_range(1, 6);
        for (int c = 0; c < nchars; c++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       text_q.push_back(8'($urandom_range(8'h01, 8'h7f)));
                    2:       text_q.push_back(8'($urandom_range(8'hc2, 8'hdf)));
                    3:       text_q.push_back(8'($urandom_range(8'he0, 8'hef)));
                    default: text_q.push_back(8'($urandom_range(8'hf0, 8'hf4)));
                endcase
                for (int k = 1; k < len; k++)
                    text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
            end
            else if (pick < 90)
            begin
                case ($urandom_range(2))
                    0:       text_q.push_back(8'h00);
                    1:       text_q.push_back(8'($urandom_range(8'h80, 8'hc1)));
                    default: text_q.push_back(8'($urandom_range(8'hf5, 8'hff)));
                endcase
            end
            else
                text_q.push_back(8'($urandom_range(8'hff)));
        end
        if (text_q.size() > 1 && $urandom_range(99) < 15)
            void'(text_q.pop_back());
    endtask

    // stimulus
    initial
    begin
        int send_mix [4];
        int recv_mix [4];
        int rand_start;

        send_mix = '{0, 74, 0, 33};
        recv_mix = '{0, 0, 74, 33};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // two-byte target shrinks to one, final byte dropped
        configure(16'd0, 21'h000041);
        text_q = '{8'hc3, 8'ha9};
        send_text();

        // largest code point in place of a four-byte character
        configure(16'd1, 21'h10ffff);
        text_q = '{8'h61, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h62};
        send_text();

        // smallest invalid code point
        configure(16'd0, 21'h110000);
        text_q = '{8'he2, 8'h82, 8'hac};
        send_text();

        // index past the end, all-ones registers
        configure(16'hffff, 21'h1fffff);
        text_q = '{8'h01, 8'h7f};
        send_text();

        // bad lead byte before the target
        configure(16'd2, 21'h000080);
        text_q = '{8'h61, 8'hff, 8'h63};
        send_text();

        // zero byte as lead
        configure(16'd0, 21'h0007ff);
        text_q = '{8'h00};
        send_text();

        // string cut inside the replaced character
        configure(16'd0, 21'h00ffff);
        text_q = '{8'hf0, 8'h90};
        send_text();

        // three-byte smallest encoding over a three-byte character
        configure(16'd1, 21'h000800);
        text_q = '{8'hc2, 8'h80, 8'he0, 8'ha0, 8'h80};
        send_text();

        // code point zero
        configure(16'd1, 21'h000000);
        text_q = '{8'h41, 8'h42};
        send_text();

        // long output hold-off while input keeps coming
        random_config();
        long_hold <= 1'b1;
        repeat (3)
        begin
            make_text();
            send_text();
        end
        long_hold <= 1'b0;
        s_tvalid  <= 1'b0;
        wait_drained();

        // random strings under each idling mix
        rand_start = bytes_sent;
        for (int p = 0; p < 4; p++)
        begin
            send_idle  = send_mix[p];
            recv_stall = recv_mix[p];
            while (bytes_sent - rand_start < RAND_BYTES * (p + 1))
            begin
                if ($urandom_range(99) < 40)
                    random_config();
                else if ($urandom_range(99) < 10)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                make_text();
                send_text();
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        $display("%0d strings, %0d bytes in, %0d results out", strings_sent, bytes_sent,
                 results);
        $display("covered replacement lengths 1-4, bad leads, invalid code points, misses");
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
